// ===== hdl/pptp_pkg.sv =====
package pptp_pkg;

    // Field widths fixed by the word formats.
    localparam int SLICE_W     = 20;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 4;
    localparam int WORD_W      = 32;
    localparam int PRIO_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int TDATA_IN_W  = 80;
    localparam int TDATA_OUT_W = 40;

    // Microseconds per millisecond and the width of a period scaled to microseconds.
    localparam int MS_US = 1000;
    localparam int THR_W = 42;

    localparam int              DEFAULT_MAX_TASKS = 16;
    localparam logic [SLICE_W-1:0] SLICE_RESET    = 20'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_US   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 1'b1;

    // Input word kinds.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] period;
        logic [PRIO_W-1:0] prio;
        logic [WORD_W-1:0] last;
    } entry_t;

    typedef struct packed {
        logic   vld;
        logic   hit;
        entry_t ent;
    } eval_t;

endpackage

// ===== hdl/periodic_priority_task_picker.sv =====
// Channel   Direction  Signals                    Contents
// s_        in         s_tvalid s_tready s_tdata  one tick or one table write per word
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata  one result word per input word
//                      m_tuser
// cfg_      in         cfg_we cfg_index cfg_wdata register writes, no read-back
//
// A table write goes from acceptance straight to the result state. A tick scans the
// first n entries, where n is task_count clamped to MAX_TASKS: the task memory is
// read one entry per cycle, and the readiness check is two stages behind the read
// port. Either result is loaded once the output register is free. The input opens
// again in the cycle after the result is loaded.
// Reset clears the counter, the configuration and all handshake state; the task table
// holds whatever it held until each entry is written.
// A stalled result sits in the output register while the next word is accepted; only
// a second finished result waits for the register to drain.
module periodic_priority_task_picker
    import pptp_pkg::*;
#(
    parameter int MAX_TASKS = DEFAULT_MAX_TASKS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0 up: entry_index[3:0], entry_period_ms[35:4],
    // entry_priority[43:36], entry_start_tick[75:44], zero fill [79:76].
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // Fields: mode[0].
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0 up: chosen_index[3:0], tick_now[35:4], zero fill [39:36].
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // Fields: chosen_valid[0].
    output logic                   m_tuser,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SLICE_W-1:0]     cfg_wdata
);

    // Address width of the task memory and a count width that holds both
    // task_count and MAX_TASKS itself.
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int NW = (CNT_W > $clog2(MAX_TASKS + 1)) ? CNT_W : $clog2(MAX_TASKS + 1);

    // Input word fields.
    logic [IDX_W-1:0]  in_index;
    entry_t            in_ent;

    assign in_index      = s_tdata[3:0];
    assign in_ent.period = s_tdata[35:4];
    assign in_ent.prio   = s_tdata[43:36];
    assign in_ent.last   = s_tdata[75:44];

    // Configuration registers.
    logic [SLICE_W-1:0] slice_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= SLICE_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLICE_US:   slice_reg <= cfg_wdata;
                REG_TASK_COUNT: count_reg <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    // Control state.
    state_t            state_reg, state_next;
    logic [WORD_W-1:0] tick_reg;
    logic [NW-1:0]     rd_cnt_reg;
    logic [NW-1:0]     scan_len_reg;
    logic              s1_vld_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic              found_reg;
    logic [AW-1:0]     best_idx_reg;
    entry_t            best_ent_reg;

    logic              out_valid_reg;
    logic              out_cv_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [WORD_W-1:0] out_tick_reg;

    logic              accept;
    logic              rd_more;
    logic              rd_en;
    logic              slot_free;
    logic              out_load;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [NW-1:0]     scan_len;
    logic              wr_in_range;
    logic              better;

    eval_t             ev;
    logic [AW-1:0]     ev_idx;

    assign accept    = s_tvalid && s_tready;
    assign rd_more   = rd_cnt_reg < scan_len_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // A task_count above MAX_TASKS scans the whole table.
    assign scan_len    = (NW'(count_reg) > NW'(MAX_TASKS)) ? NW'(MAX_TASKS) : NW'(count_reg);
    assign wr_in_range = NW'(in_index) < NW'(MAX_TASKS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == MODE_WRITE) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Leave once every read entry has passed the compare stage.
                if (!rd_more && !s1_vld_reg && !ev.vld)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs. The memory takes a table write at acceptance and the
    // winner's write-back when the result leaves; the two never coincide.
    always_comb
    begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = AW'(in_index);
        mem_wdata = in_ent;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                mem_we   = s_tvalid && (s_tuser == MODE_WRITE) && wr_in_range;
            end
            ST_SCAN:
            begin
                rd_en = rd_more;
            end
            ST_RESULT:
            begin
                out_load         = slot_free;
                mem_we           = slot_free && found_reg;
                mem_waddr        = best_idx_reg;
                mem_wdata.period = best_ent_reg.period;
                mem_wdata.prio   = best_ent_reg.prio;
                mem_wdata.last   = tick_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Task memory: one write port, one registered read port.
    entry_t mem [MAX_TASKS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
        end
    end

    // Elapsed time against period, two stages behind the read port.
    pptp_entry_eval #(
        .AW (AW)
    ) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (s1_vld_reg),
        .in_idx (s1_idx_reg),
        .in_ent (rd_data_reg),
        .tick   (tick_reg),
        .slice  (slice_reg),
        .ev     (ev),
        .ev_idx (ev_idx)
    );

    // Lower priority number wins; on a tie the strictly older last run wins,
    // so an exact tie keeps the earlier index.
    always_comb
    begin
        priority if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (ev.ent.prio < best_ent_reg.prio)
        begin
            better = 1'b1;
        end
        else if (ev.ent.prio == best_ent_reg.prio && ev.ent.last < best_ent_reg.last)
        begin
            better = 1'b1;
        end
        else
        begin
            better = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            rd_cnt_reg   <= '0;
            scan_len_reg <= '0;
            s1_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= rd_en;
            if (accept)
            begin
                found_reg <= 1'b0;
                if (s_tuser == MODE_TICK)
                begin
                    tick_reg     <= tick_reg + 1'b1;
                    rd_cnt_reg   <= '0;
                    scan_len_reg <= scan_len;
                end
            end
            else
            begin
                if (rd_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (ev.vld && ev.hit && better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= rd_cnt_reg[AW-1:0];
        if (ev.vld && ev.hit && better)
        begin
            best_idx_reg <= ev_idx;
            best_ent_reg <= ev.ent;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cv_reg   <= found_reg;
            out_idx_reg  <= found_reg ? IDX_W'(best_idx_reg) : '0;
            out_tick_reg <= tick_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_tick_reg, out_idx_reg};
    assign m_tuser  = out_cv_reg;

endmodule

// ===== hdl/pptp_entry_eval.sv =====
module pptp_entry_eval
    import pptp_pkg::*;
#(
    parameter int AW = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [AW-1:0]      in_idx,
    input  entry_t             in_ent,
    input  logic [WORD_W-1:0]  tick,
    input  logic [SLICE_W-1:0] slice,
    output eval_t              ev,
    output logic [AW-1:0]      ev_idx
);

    logic [WORD_W-1:0]         elapsed;
    logic [WORD_W+SLICE_W-1:0] prod;
    logic [THR_W-1:0]          thr_next;

    logic                      vld_reg;
    logic [AW-1:0]             idx_reg;
    entry_t                    ent_reg;
    logic [WORD_W-1:0]         us_reg;
    logic [THR_W-1:0]          thr_reg;

    // floor(us / 1000) >= period holds exactly when us >= period * 1000.
    always_comb
    begin
        elapsed  = tick - in_ent.last;
        prod     = elapsed * slice;
        thr_next = THR_W'(in_ent.period) * THR_W'(MS_US);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= in_idx;
        ent_reg <= in_ent;
        us_reg  <= prod[WORD_W-1:0];
        thr_reg <= thr_next;
    end

    assign ev.vld  = vld_reg;
    assign ev.hit  = THR_W'(us_reg) >= thr_reg;
    assign ev.ent  = ent_reg;
    assign ev_idx  = idx_reg;

endmodule

// ===== hdl/pptp_checker.sv =====
module pptp_checker
    import pptp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // One word at a time: the input side closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // No winner means index zero.
    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[3:0] == 4'd0))
        else $error("nonzero index without a winner");

    // A new result is loaded only while the input side is closed for the item
    // that produced it.
    a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the input side was open");

endmodule

bind periodic_priority_task_picker pptp_checker u_pptp_checker (.*);

// ===== bench/tb_periodic_priority_task_picker.sv =====
module tb_periodic_priority_task_picker;
    import pptp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One result word as the checker sees it. chosen_valid travels on m_tuser.
    typedef struct {
        logic              chosen_valid;
        logic [IDX_W-1:0]  chosen_index;
        logic [WORD_W-1:0] tick_now;
    } pick_t;

    // Every block input holds a known value from time zero, and reset is asserted
    // from the start.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // Fields from bit 0 up: entry_index, entry_period_ms, entry_priority,
    // entry_start_tick, zero fill.
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    // Fields: mode.
    logic                   s_tuser   = MODE_TICK;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // Fields from bit 0 up: chosen_index, tick_now, zero fill.
    logic [TDATA_OUT_W-1:0] m_tdata;
    // Fields: chosen_valid.
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_SLICE_US;
    logic [SLICE_W-1:0]     cfg_wdata = '0;

    periodic_priority_task_picker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // The bench keeps its own copy of the scheduler: tick counter, task table and
    // the two configuration registers, all at their reset values. The table
    // contents do not matter until written; the stimulus loads every entry
    // before any tick scans it.
    logic [WORD_W-1:0]  tick_cnt  = '0;
    logic [WORD_W-1:0]  last_tbl   [DEFAULT_MAX_TASKS] = '{default: '0};
    logic [WORD_W-1:0]  period_tbl [DEFAULT_MAX_TASKS] = '{default: '0};
    logic [PRIO_W-1:0]  prio_tbl   [DEFAULT_MAX_TASKS] = '{default: '0};
    logic [SLICE_W-1:0] slice_cfg = SLICE_RESET;
    logic [CNT_W-1:0]   count_cfg = '0;

    // Picks predicted for accepted words, oldest first.
    pick_t pending_picks[$];
    int    mismatches = 0;

    // Traffic shaping. gaps_on lets the sender pause between bursts, stall_on
    // lets the receiver drop tready on its own pattern, and hold_req asks the
    // receiver for one long hold-off of that many cycles.
    bit gaps_on    = 1'b0;
    bit stall_on   = 1'b0;
    int burst_left = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int rx_cycle   = 0;

    // Applies one accepted word to the bench's copy of the scheduler and returns
    // the result word the block must produce for it. A write loads one entry and
    // leaves the counter alone. A tick bumps the counter, then walks the entries
    // in use: an entry is ready once its elapsed time in ms, computed with 32-bit
    // wrapping arithmetic, reaches its period. The lowest priority number wins,
    // a strictly older last run breaks a priority tie, and otherwise the lower
    // index keeps the win. The winner's last run becomes the new counter value.
    function automatic pick_t pick_next_task(input logic mode,
                                             input logic [TDATA_IN_W-1:0] w);
        pick_t             res;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] elapsed;
        logic [WORD_W-1:0] us;
        int                n;
        int                best;
        bit                found;

        found = 1'b0;
        best  = 0;
        if (mode == MODE_WRITE) begin
            idx             = w[IDX_W-1:0];
            period_tbl[idx] = w[IDX_W +: WORD_W];
            prio_tbl[idx]   = w[IDX_W+WORD_W +: PRIO_W];
            last_tbl[idx]   = w[IDX_W+WORD_W+PRIO_W +: WORD_W];
        end
        else begin
            // A task count beyond the table size scans the whole table.
            n = (count_cfg > DEFAULT_MAX_TASKS) ? DEFAULT_MAX_TASKS : int'(count_cfg);
            tick_cnt = tick_cnt + 1'b1;
            for (int k = 0; k < n; k++) begin
                elapsed = tick_cnt - last_tbl[k];
                us      = elapsed * WORD_W'(slice_cfg);
                if (us / WORD_W'(MS_US) >= period_tbl[k]) begin
                    if (!found || prio_tbl[k] < prio_tbl[best] ||
                        (prio_tbl[k] == prio_tbl[best] && last_tbl[k] < last_tbl[best]))
                    begin
                        found = 1'b1;
                        best  = k;
                    end
                end
            end
            if (found)
                last_tbl[best] = tick_cnt;
        end
        res.chosen_valid = found;
        res.chosen_index = found ? IDX_W'(best) : '0;
        res.tick_now     = tick_cnt;
        return res;
    endfunction

    function automatic logic [TDATA_IN_W-1:0] pack_entry(input logic [IDX_W-1:0]  idx,
                                                         input logic [WORD_W-1:0] period,
                                                         input logic [PRIO_W-1:0] prio,
                                                         input logic [WORD_W-1:0] start);
        return {4'b0000, start, prio, period, idx};
    endfunction

    // Offers one word and blocks until the block takes it. Called at a rising
    // edge. When gaps are enabled the sender works in bursts, and tvalid drops for
    // a random number of cycles once a burst is used up. tvalid stays high between
    // back-to-back words, so it never gets two assignments in one time step.
    task automatic offer_word(input logic mode, input logic [TDATA_IN_W-1:0] w);
        int gap;

        if (gaps_on && burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        pending_picks.push_back(pick_next_task(mode, w));
        burst_left--;
    endtask

    // Builds a random word that mostly makes sense for the current settings:
    // periods scaled to the slice so that tasks fall due within a few dozen ticks,
    // a narrow priority range so that ties are common, and start ticks just
    // behind the counter. A share of fully random values covers every bit and the
    // wrapping cases. Write fields on a tick word carry the same random values.
    task automatic offer_random_item(input int tick_pct);
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] start;
        logic [PRIO_W-1:0] prio;
        logic              mode;
        int                roll;

        idx  = $urandom_range(0, DEFAULT_MAX_TASKS - 1);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            period = $urandom;
        else if (roll < 25)
            period = '0;
        else
            period = (WORD_W'(slice_cfg) * WORD_W'($urandom_range(0, 24))) / WORD_W'(MS_US);
        prio  = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 3));
        start = ($urandom_range(0, 7) == 0) ? WORD_W'($urandom)
                                            : tick_cnt - WORD_W'($urandom_range(0, 30));
        mode  = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_WRITE;
        offer_word(mode, pack_entry(idx, period, prio, start));
    endtask

    // Drops tvalid and waits, with a limit, until every predicted pick has come
    // back, then waits on so that the block is surely idle before any register write.
    task automatic drain_picks();
        int waited;

        s_tvalid <= 1'b0;
        burst_left = 0;
        waited     = 0;
        while (pending_picks.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        if (pending_picks.size() != 0) begin
            $error("%0d result words never arrived", pending_picks.size());
            mismatches++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Register write: one cycle with the write enable high, then one low so that
    // a following write raises it again in a later time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLICE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_SLICE_US)
            slice_cfg = value;
        else
            count_cfg = value[CNT_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receive side. Each accepted word is checked against the oldest pick still
    // pending. tready follows either a long hold-off, a stall pattern of its own
    // (a fixed duty cycle with random holes), or stays high.
    always @(posedge clk)
    begin : receive_side
        pick_t want;

        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_picks.size() == 0) begin
                    $error("result word with no pick pending: index %0d tick %0d",
                           m_tdata[IDX_W-1:0], m_tdata[IDX_W +: WORD_W]);
                    mismatches++;
                end
                else begin
                    want = pending_picks.pop_front();
                    if (m_tuser !== want.chosen_valid) begin
                        $error("chosen_valid: expected %0d, actual %0d",
                               want.chosen_valid, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[IDX_W-1:0] !== want.chosen_index) begin
                        $error("chosen_index: expected %0d, actual %0d",
                               want.chosen_index, m_tdata[IDX_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[IDX_W +: WORD_W] !== want.tick_now) begin
                        $error("tick_now: expected %0d, actual %0d",
                               want.tick_now, m_tdata[IDX_W +: WORD_W]);
                        mismatches++;
                    end
                end
            end
            if (hold_left == 0 && hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_on)
                m_tready <= ((rx_cycle % 9) < 6) && ($urandom_range(0, 3) != 0);
            else
                m_tready <= 1'b1;
            rx_cycle++;
        end
    end

    // Ticks with no entries in use: nothing is picked, but the counter still
    // moves. The ignored write fields run from all zeros to all ones.
    task automatic check_idle_ticks();
        offer_word(MODE_TICK, pack_entry('0, '0, '0, '0));
        offer_word(MODE_TICK, pack_entry('1, '1, '1, '1));
        offer_word(MODE_TICK, pack_entry(IDX_W'($urandom), $urandom, PRIO_W'($urandom), $urandom));
    endtask

    // Loads all sixteen entries so that no tick ever scans an unwritten one.
    // Entry 0 is the most urgent but its period can never elapse. Entries 1 and 2
    // are a full tie that is always ready. Entry 3 starts with its last run ahead
    // of the counter, so the elapsed count wraps. Entry 4 is the least urgent and
    // starts far back, so the product with the slice wraps. Entry 15 falls due
    // after a few ticks and then beats the tie.
    task automatic load_task_table();
        offer_word(MODE_WRITE, pack_entry(4'd0, '1, 8'd0, '0));
        offer_word(MODE_WRITE, pack_entry(4'd1, '0, 8'd7, '0));
        offer_word(MODE_WRITE, pack_entry(4'd2, '0, 8'd7, '0));
        offer_word(MODE_WRITE, pack_entry(4'd3, 32'd2, 8'd2, '1));
        offer_word(MODE_WRITE, pack_entry(4'd4, 32'd1, 8'd255, 32'h8000_0000));
        for (int k = 5; k < DEFAULT_MAX_TASKS - 1; k++)
            offer_word(MODE_WRITE, pack_entry(IDX_W'(k), WORD_W'($urandom_range(4, 40)),
                                              PRIO_W'($urandom_range(8, 255)), '0));
        offer_word(MODE_WRITE, pack_entry(4'd15, 32'd3, 8'd1, '0));
    endtask

    // Scans over the directed table: the full table at the default slice, a task
    // count beyond the table size with a zero slice (only zero periods are ready),
    // and a single entry at the largest slice the bench uses.
    task automatic check_scan_corners();
        drain_picks();
        write_reg(REG_TASK_COUNT, SLICE_W'(DEFAULT_MAX_TASKS));
        repeat (4) offer_word(MODE_TICK, pack_entry('0, '0, '0, '0));
        drain_picks();
        write_reg(REG_TASK_COUNT, SLICE_W'(31));
        write_reg(REG_SLICE_US, '0);
        repeat (2) offer_word(MODE_TICK, pack_entry('1, '1, '1, '1));
        drain_picks();
        write_reg(REG_TASK_COUNT, SLICE_W'(1));
        write_reg(REG_SLICE_US, SLICE_W'(1_000_000));
        repeat (2) offer_word(MODE_TICK, pack_entry('0, '0, '0, '0));
    endtask

    // Random words in phases. Each phase sets a new slice and task count (both
    // ends of each range among them) and a new mix of sender gaps and receiver
    // stalls; the first phase runs with neither.
    task automatic run_random_sweep();
        logic [SLICE_W-1:0] slice;
        logic [SLICE_W-1:0] count;

        for (int ph = 0; ph < 12; ph++) begin
            drain_picks();
            case (ph % 6)
                0:       slice = SLICE_RESET;
                1:       slice = SLICE_W'(1);
                2:       slice = SLICE_W'(1_000_000);
                3:       slice = SLICE_W'($urandom_range(1, 1_000_000));
                4:       slice = SLICE_W'($urandom_range(100, 5000));
                default: slice = SLICE_W'($urandom_range(500, 2000));
            endcase
            case (ph % 4)
                0:       count = SLICE_W'(DEFAULT_MAX_TASKS);
                1:       count = SLICE_W'($urandom_range(1, DEFAULT_MAX_TASKS));
                2:       count = (ph == 2) ? '0 : SLICE_W'($urandom_range(2, DEFAULT_MAX_TASKS));
                default: count = SLICE_W'(31);
            endcase
            write_reg(REG_SLICE_US, slice);
            write_reg(REG_TASK_COUNT, count);
            gaps_on  = (ph % 3 != 0);
            stall_on = (ph % 4 != 0);
            repeat (150) offer_random_item(80);
        end
    endtask

    // The receiver holds tready low for a long stretch while the sender keeps
    // offering words back to back, so the output register and the finished result
    // behind it fill up and the block has to stall its input.
    task automatic check_output_backpressure();
        drain_picks();
        write_reg(REG_SLICE_US, SLICE_RESET);
        write_reg(REG_TASK_COUNT, SLICE_W'(DEFAULT_MAX_TASKS));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        hold_req = 300;
        repeat (40) offer_random_item(70);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_idle_ticks();
        load_task_table();
        check_scan_corners();
        run_random_sweep();
        check_output_backpressure();
        drain_picks();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a normal run takes a small fraction of this.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
